/* design/jsu_pkg.sv */
// Shared types, character codes and helpers for the JSON string unescape block.
`timescale 1ns / 1ps
package jsu_pkg;

  // Decoder phase within one string literal.
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_TEXT = 2'd1,
    PH_ESC  = 2'd2,
    PH_HEX  = 2'd3
  } phase_t;

  // Result kind codes as they appear on the output port.
  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_END  = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  // Character codes seen in the raw text.
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_N = 8'h6E;
  localparam logic [7:0] CH_T = 8'h74;
  localparam logic [7:0] CH_R = 8'h72;
  localparam logic [7:0] CH_B = 8'h62;
  localparam logic [7:0] CH_F = 8'h66;
  localparam logic [7:0] CH_U = 8'h75;

  // Control bytes that the short escapes stand for.
  localparam logic [7:0] CTL_LF = 8'h0A;
  localparam logic [7:0] CTL_TAB = 8'h09;
  localparam logic [7:0] CTL_CR = 8'h0D;
  localparam logic [7:0] CTL_BS = 8'h08;
  localparam logic [7:0] CTL_FF = 8'h0C;

  // Code point bounds for one- and two-byte UTF-8.
  localparam logic [15:0] UTF8_ONE_LIMIT = 16'h0080;
  localparam logic [15:0] UTF8_TWO_LIMIT = 16'h0800;

  localparam int MaxResults = 3;

  // Results caused by one input byte: count, common kind and up to three bytes.
  typedef struct packed {
    logic [1:0]                  cnt;
    kind_t                       kind;
    logic [MaxResults-1:0][7:0]  bytes;
  } res_t;

  // Hex digit value; bit 4 is set when the byte is a valid hex digit.
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, b[3:0]};
    end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
      r = {1'b1, b[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

/* design/jsu_decode.sv */
// Escape decoder: phase state and the results that one raw byte produces.
`timescale 1ns / 1ps
module jsu_decode import jsu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] in_byte,
  output res_t       res
);

  phase_t      phase, phase_next;
  logic [1:0]  hex_count, hex_count_next;
  logic [15:0] code_point, code_point_next;

  logic [4:0]  hd;
  logic [15:0] cp_full;

  assign hd = hex_digit(in_byte);
  assign cp_full = {code_point[11:0], hd[3:0]};

  // Next state and result set for the byte being transferred.
  always_comb begin
    phase_next = phase;
    hex_count_next = hex_count;
    code_point_next = code_point;
    res.cnt = 2'd0;
    res.kind = KIND_DATA;
    res.bytes = '0;
    case (phase)
      PH_IDLE: begin
        if (in_byte == CH_QUOTE) begin
          phase_next = PH_TEXT;
        end else begin
          res.cnt = 2'd1;
          res.kind = KIND_ERR;
        end
      end
      PH_TEXT: begin
        if (in_byte == CH_QUOTE) begin
          res.cnt = 2'd1;
          res.kind = KIND_END;
          phase_next = PH_IDLE;
          hex_count_next = 2'd0;
          code_point_next = 16'd0;
        end else if (in_byte == CH_BSLASH) begin
          phase_next = PH_ESC;
        end else begin
          res.cnt = 2'd1;
          res.bytes[0] = in_byte;
        end
      end
      PH_ESC: begin
        phase_next = PH_TEXT;
        res.cnt = 2'd1;
        case (in_byte)
          CH_N: res.bytes[0] = CTL_LF;
          CH_T: res.bytes[0] = CTL_TAB;
          CH_R: res.bytes[0] = CTL_CR;
          CH_B: res.bytes[0] = CTL_BS;
          CH_F: res.bytes[0] = CTL_FF;
          CH_U: begin
            res.cnt = 2'd0;
            phase_next = PH_HEX;
            hex_count_next = 2'd0;
            code_point_next = 16'd0;
          end
          default: res.bytes[0] = in_byte;
        endcase
      end
      default: begin
        if (!hd[4]) begin
          // A bad hex digit aborts the string.
          res.cnt = 2'd1;
          res.kind = KIND_ERR;
          phase_next = PH_IDLE;
          hex_count_next = 2'd0;
          code_point_next = 16'd0;
        end else if (hex_count == 2'd3) begin
          // Fourth digit: encode the code point as UTF-8.
          if (cp_full < UTF8_ONE_LIMIT) begin
            res.cnt = 2'd1;
            res.bytes[0] = cp_full[7:0];
          end else if (cp_full < UTF8_TWO_LIMIT) begin
            res.cnt = 2'd2;
            res.bytes[0] = {3'b110, cp_full[10:6]};
            res.bytes[1] = {2'b10, cp_full[5:0]};
          end else begin
            res.cnt = 2'd3;
            res.bytes[0] = {4'b1110, cp_full[15:12]};
            res.bytes[1] = {2'b10, cp_full[11:6]};
            res.bytes[2] = {2'b10, cp_full[5:0]};
          end
          phase_next = PH_TEXT;
          hex_count_next = 2'd0;
          code_point_next = 16'd0;
        end else begin
          code_point_next = cp_full;
          hex_count_next = hex_count + 2'd1;
        end
      end
    endcase
  end

  // State registers advance only on an input transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      hex_count <= 2'd0;
      code_point <= 16'd0;
    end else if (accept) begin
      phase <= phase_next;
      hex_count <= hex_count_next;
      code_point <= code_point_next;
    end
  end

endmodule

/* design/json_string_unescape.sv */
// The first result of a byte is valid in the cycle after its input transfer.
// Throughput: one input byte per cycle while each byte yields at most one result and
// out_ready is high; extra results of a byte stall input until the last one is taken.
// The result buffer sits between the decoder and the output port.
// Reset (synchronous, active high) empties the buffer and returns the decoder to idle.
`timescale 1ns / 1ps
module json_string_unescape import jsu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic [1:0] kind,
  output logic       last
);

  res_t            res;
  logic            in_xfer;
  logic            out_xfer;
  logic [1:0]      cnt;
  kind_t           buf_kind;
  logic [2:0][7:0] bytes;

  jsu_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .accept  (in_xfer),
    .in_byte (in_byte),
    .res     (res)
  );

  // Accept when the buffer is empty now or empties in this cycle.
  assign in_ready = (cnt == 2'd0) || (cnt == 2'd1 && out_ready);
  assign in_xfer = in_valid && in_ready;
  assign out_valid = (cnt != 2'd0);
  assign out_xfer = out_valid && out_ready;

  assign out_byte = bytes[0];
  assign kind = buf_kind;
  assign last = (cnt == 2'd1);

  // Result buffer: head entry is on the port, later entries shift forward.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (in_xfer) begin
      cnt <= res.cnt;
    end else if (out_xfer) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      bytes <= res.bytes;
      buf_kind <= res.kind;
    end else if (out_xfer) begin
      bytes <= {8'd0, bytes[2], bytes[1]};
    end
  end

  // An end or error result is always the only result of its byte.
  a_single_marker: assert property (@(posedge clk) disable iff (rst)
    out_valid && buf_kind != KIND_DATA |-> cnt == 2'd1)
    else $error("end or error marker not alone in buffer");

  // A new byte is only taken when no earlier result would be overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    in_xfer |-> cnt == 2'd0 || (cnt == 2'd1 && out_xfer))
    else $error("input transfer while results still pending");

  // Without a new byte, a delivered result shortens the buffer by one.
  a_drain: assert property (@(posedge clk) disable iff (rst)
    out_xfer && !in_xfer |=> cnt == $past(cnt) - 2'd1)
    else $error("buffer count did not drop after output transfer");

  // Reset leaves the buffer empty.
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> cnt == 2'd0)
    else $error("buffer not empty after reset");

endmodule
